[hdl/rrc_pkg.sv]
// Shared types, constants and helpers for the rounded rectangle coverage block.
package rrc_pkg;

  localparam int unsigned RRC_MAX_DIM = 4096;
  localparam int CFG_W  = 13;
  localparam int POS_W  = 14;
  localparam int COV_W  = 8;
  localparam int IDX_W  = 2;
  localparam int SUB_N  = 4;
  localparam int HITS_W = 5;
  localparam int SAMPLES = SUB_N * SUB_N;

  localparam logic [IDX_W-1:0] REG_RECT_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RECT_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CORNER_RADIUS = 2'd2;

  localparam logic [COV_W-1:0] COV_NONE = 8'd0;
  localparam logic [COV_W-1:0] COV_FULL = 8'd255;

  typedef struct packed {
    logic vld;
    logic outside;
    logic full;
  } rrc_ctl_t;

  function automatic logic [COV_W-1:0] rrc_scale(input logic [HITS_W-1:0] hits);
    logic [HITS_W+8-1:0] prod;
    prod = {hits, 8'd0} - (HITS_W + 8)'(hits) + (HITS_W + 8)'(8);
    return prod[COV_W+3:4];
  endfunction

endpackage

[hdl/rrc_geom.sv]
// Geometry stages: clamp the dimensions, test inside, mirror into the corner.
module rrc_geom #(
  parameter int unsigned MAX_DIM = rrc_pkg::RRC_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [rrc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rrc_pkg::POS_W-1:0] in_pos_y,
  input  logic [rrc_pkg::CFG_W-1:0]        rect_width,
  input  logic [rrc_pkg::CFG_W-1:0]        rect_height,
  input  logic [rrc_pkg::CFG_W-1:0]        corner_radius,
  output rrc_pkg::rrc_ctl_t                ctl_o,
  output logic [$clog2(2*MAX_DIM)-1:0]     mx_o,
  output logic [$clog2(2*MAX_DIM)-1:0]     my_o,
  output logic [$clog2(2*MAX_DIM)-1:0]     c_o
);
  import rrc_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int KW = (DW > CFG_W) ? DW : CFG_W;
  localparam int CW = $clog2(2 * MAX_DIM);

  logic [KW-1:0] lim;
  logic [KW-1:0] w_sat, h_sat, r_sat, r_w, r_eff;
  logic [KW-1:0] xu, yu;
  logic          outside;

  rrc_ctl_t      a_ctl_r;
  logic [KW-1:0] a_x_r, a_y_r, a_w_r, a_h_r, a_r_r;

  logic [KW-1:0]   xm, ym;
  logic            full;
  logic [KW+1:0]   r4;

  rrc_ctl_t        b_ctl_r;
  logic [CW-1:0]   b_mx_r, b_my_r, b_c_r;

  always_comb begin
    lim     = KW'(MAX_DIM);
    w_sat   = (KW'(rect_width) > lim) ? lim : KW'(rect_width);
    h_sat   = (KW'(rect_height) > lim) ? lim : KW'(rect_height);
    r_sat   = (KW'(corner_radius) > lim) ? lim : KW'(corner_radius);
    r_w     = (r_sat > (w_sat >> 1)) ? (w_sat >> 1) : r_sat;
    r_eff   = (r_w > (h_sat >> 1)) ? (h_sat >> 1) : r_w;
    xu      = KW'(in_pos_x[POS_W-2:0]);
    yu      = KW'(in_pos_y[POS_W-2:0]);
    outside = in_pos_x[POS_W-1] || in_pos_y[POS_W-1] || (xu >= w_sat) || (yu >= h_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else if (adv) begin
      a_ctl_r <= '{vld: in_valid, outside: outside, full: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r <= xu;
      a_y_r <= yu;
      a_w_r <= w_sat;
      a_h_r <= h_sat;
      a_r_r <= r_eff;
    end
  end

  always_comb begin
    xm   = (a_x_r >= a_w_r - a_r_r) ? (a_w_r - KW'(1) - a_x_r) : a_x_r;
    ym   = (a_y_r >= a_h_r - a_r_r) ? (a_h_r - KW'(1) - a_y_r) : a_y_r;
    full = (a_r_r == '0) || (xm >= a_r_r) || (ym >= a_r_r);
    r4   = {a_r_r, 2'b00} - (KW + 2)'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else if (adv) begin
      b_ctl_r <= '{vld: a_ctl_r.vld, outside: a_ctl_r.outside, full: full};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mx_r <= CW'(xm);
      b_my_r <= CW'(ym);
      b_c_r  <= CW'(r4);
    end
  end

  assign ctl_o = b_ctl_r;
  assign mx_o  = b_mx_r;
  assign my_o  = b_my_r;
  assign c_o   = b_c_r;

endmodule

[hdl/rrc_sample.sv]
// Subsample stages: square the offsets, test 16 samples against the circle, count hits.
module rrc_sample #(
  parameter int unsigned MAX_DIM = rrc_pkg::RRC_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  rrc_pkg::rrc_ctl_t                ctl_i,
  input  logic [$clog2(2*MAX_DIM)-1:0]     mx_i,
  input  logic [$clog2(2*MAX_DIM)-1:0]     my_i,
  input  logic [$clog2(2*MAX_DIM)-1:0]     c_i,
  output rrc_pkg::rrc_ctl_t                ctl_o,
  output logic [rrc_pkg::HITS_W-1:0]       hits_o
);
  import rrc_pkg::*;

  localparam int CW = $clog2(2 * MAX_DIM);
  localparam int SW = 2 * CW;

  logic [CW:0]   bx, by;
  logic [CW:0]   dx [SUB_N];
  logic [CW:0]   dy [SUB_N];
  logic [CW-1:0] ax [SUB_N];
  logic [CW-1:0] ay [SUB_N];

  rrc_ctl_t      c_ctl_r;
  logic [SW-1:0] sqx_r [SUB_N];
  logic [SW-1:0] sqy_r [SUB_N];
  logic [SW-1:0] rr_r;

  logic [HITS_W-1:0] hits_nxt;
  rrc_ctl_t          d_ctl_r;
  logic [HITS_W-1:0] d_hits_r;

  always_comb begin
    bx = (CW + 1)'(c_i) - (CW + 1)'({mx_i, 2'b00});
    by = (CW + 1)'(c_i) - (CW + 1)'({my_i, 2'b00});
    for (int k = 0; k < SUB_N; k++) begin
      dx[k] = bx - (CW + 1)'(k);
      dy[k] = by - (CW + 1)'(k);
      ax[k] = dx[k][CW] ? CW'(-dx[k]) : CW'(dx[k]);
      ay[k] = dy[k][CW] ? CW'(-dy[k]) : CW'(dy[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else if (adv) begin
      c_ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SUB_N; k++) begin
        sqx_r[k] <= SW'(ax[k]) * SW'(ax[k]);
        sqy_r[k] <= SW'(ay[k]) * SW'(ay[k]);
      end
      rr_r <= SW'(c_i) * SW'(c_i);
    end
  end

  always_comb begin
    hits_nxt = '0;
    for (int j = 0; j < SUB_N; j++) begin
      for (int i = 0; i < SUB_N; i++) begin
        hits_nxt = hits_nxt +
          HITS_W'(((SW + 1)'(sqx_r[i]) + (SW + 1)'(sqy_r[j])) <= (SW + 1)'(rr_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r <= '0;
    end else if (adv) begin
      d_ctl_r <= c_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_hits_r <= hits_nxt;
    end
  end

  assign ctl_o  = d_ctl_r;
  assign hits_o = d_hits_r;

endmodule

[hdl/rounded_rect_coverage.sv]
// Rounded rectangle coverage: per-pixel 8-bit coverage with 4x4 corner supersampling.
//
// Input channel: in_valid / in_stall with in_pos_x, in_pos_y (local pixel, signed).
// Output channel: out_valid / out_stall with out_coverage, one result per request.
// Config port: cfg_we writes cfg_wdata into rect_width (index 0), rect_height (1)
// or corner_radius (2); other indexes are ignored. Write only while no request
// is in flight.
// Throughput: one request per cycle unless out_stall holds; the pipeline has five
// register stages, and a result shows on out_valid after passing through them all.
// The squaring stage (eight offset squares and one radius square) sets the depth.
// Reset clears all valid bits and the three registers to zero.
// While out_stall holds a waiting result, the whole pipeline holds and in_stall
// rises; nothing is dropped or repeated.
module rounded_rect_coverage #(
  parameter int unsigned MAX_DIM = rrc_pkg::RRC_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rrc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rrc_pkg::POS_W-1:0] in_pos_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rrc_pkg::COV_W-1:0]        out_coverage,
  input  logic                             cfg_we,
  input  logic [rrc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]        cfg_wdata
);
  import rrc_pkg::*;

  localparam int CW = $clog2(2 * MAX_DIM);

  logic [CFG_W-1:0] rect_width_r, rect_height_r, corner_radius_r;
  logic             adv;

  rrc_ctl_t          geom_ctl, samp_ctl;
  logic [CW-1:0]     geom_mx, geom_my, geom_c;
  logic [HITS_W-1:0] samp_hits;

  logic [COV_W-1:0] cov_nxt;
  logic             out_valid_r;
  logic [COV_W-1:0] out_coverage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_width_r    <= '0;
      rect_height_r   <= '0;
      corner_radius_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECT_WIDTH:    rect_width_r    <= cfg_wdata;
        REG_RECT_HEIGHT:   rect_height_r   <= cfg_wdata;
        REG_CORNER_RADIUS: corner_radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  rrc_geom #(.MAX_DIM(MAX_DIM)) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .rect_width    (rect_width_r),
    .rect_height   (rect_height_r),
    .corner_radius (corner_radius_r),
    .ctl_o         (geom_ctl),
    .mx_o          (geom_mx),
    .my_o          (geom_my),
    .c_o           (geom_c)
  );

  rrc_sample #(.MAX_DIM(MAX_DIM)) u_sample (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_i  (geom_ctl),
    .mx_i   (geom_mx),
    .my_i   (geom_my),
    .c_i    (geom_c),
    .ctl_o  (samp_ctl),
    .hits_o (samp_hits)
  );

  always_comb begin
    priority if (samp_ctl.outside) begin
      cov_nxt = COV_NONE;
    end else if (samp_ctl.full) begin
      cov_nxt = COV_FULL;
    end else begin
      cov_nxt = rrc_scale(samp_hits);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= samp_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_coverage_r <= cov_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_coverage = out_coverage_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_hits_range: assert property (@(posedge clk) disable iff (!rst_n)
    samp_ctl.vld |-> samp_hits <= HITS_W'(SAMPLES))
    else $error("hit count above sample count");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && samp_ctl.vld && samp_ctl.outside |=> out_valid && out_coverage == COV_NONE)
    else $error("outside point with nonzero coverage");
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input held off with empty output register");
`endif

endmodule
